>>> rtl/assert_macros.svh
// Assertion macros for the RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mwtg_pkg.sv
// Package for the tone generator: sizes, register and waveform codes,
// and the elaboration-time build of the Q1.15 sine table. No dependencies.
`timescale 1ns / 1ps

package mwtg_pkg;

    // Table depth must be a power of two (64 .. 65536).
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int POSITION_WIDTH   = 24;

    localparam int PHASE_W   = 32;
    localparam int AMP_W     = 15;
    localparam int SEG_W     = 24;
    localparam int SLOPE_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = POSITION_WIDTH + SLOPE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVEFORM       = 3'd0,
        REG_AMPLITUDE      = 3'd1,
        REG_SEGMENT_LENGTH = 3'd2,
        REG_SLOPE          = 3'd3,
        REG_PHASE_STEP     = 3'd4,
        REG_SAMPLE_COUNT   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } wave_t;

    typedef logic signed [SAMPLE_W-1:0] sine_lut_t [SINE_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // Quarter-wave fold, Q30 Horner series to x^11, clamp, scale, round half up.
    function automatic sine_lut_t sine_lut_build();
        sine_lut_t   lut;
        logic [63:0] u;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            u    = 64'(k) << 2;
            quad = (u / SINE_TABLE_DEPTH) & 64'd3;
            rem  = u % SINE_TABLE_DEPTH;
            if (quad == 64'd1 || quad == 64'd3)
            begin
                rem = 64'(SINE_TABLE_DEPTH) - rem;
            end
            x  = (HALF_PI_Q30 * rem) / SINE_TABLE_DEPTH;
            x2 = q30_mul(x, x);
            t  = Q30_ONE - x2 / 64'd110;
            t  = Q30_ONE - q30_mul(x2, t) / 64'd72;
            t  = Q30_ONE - q30_mul(x2, t) / 64'd42;
            t  = Q30_ONE - q30_mul(x2, t) / 64'd20;
            t  = Q30_ONE - q30_mul(x2, t) / 64'd6;
            s  = q30_mul(x, t);
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            lut[k] = (quad >= 64'd2) ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = sine_lut_build();

endpackage

>>> rtl/multi_waveform_tone_generator.sv
// Multi-waveform tone generator: sine, square, triangle, sawtooth samples.
// Throughput: one beat per cycle unless out_stall holds the pipe. Each accepted
// beat is registered in stage 1 (sine ROM read and ramp multiply), then at the output.
// Reset: configuration returns to defaults, sound state to zero, pipeline empty.
// Depends on mwtg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_waveform_tone_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [mwtg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mwtg_pkg::CFG_W-1:0]       cfg_data,
    // input channel: one tick per beat
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             start_req,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [mwtg_pkg::SAMPLE_W-1:0] sample,
    output logic                             last
);
    import mwtg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    wave_t               waveform_reg;
    logic [AMP_W-1:0]    amplitude_reg;
    logic [SEG_W-1:0]    segment_length_reg;
    logic [SLOPE_W-1:0]  slope_reg;
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [COUNT_W-1:0]  sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg       <= WAVE_SINE;
            amplitude_reg      <= '0;
            segment_length_reg <= SEG_W'(1);
            slope_reg          <= '0;
            phase_step_reg     <= '0;
            sample_count_reg   <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            // Out-of-range indices are dropped.
            unique case (cfg_index)
                REG_WAVEFORM:       waveform_reg       <= wave_t'(cfg_data[1:0]);
                REG_AMPLITUDE:      amplitude_reg      <= cfg_data[AMP_W-1:0];
                REG_SEGMENT_LENGTH: segment_length_reg <= cfg_data[SEG_W-1:0];
                REG_SLOPE:          slope_reg          <= cfg_data[SLOPE_W-1:0];
                REG_PHASE_STEP:     phase_step_reg     <= cfg_data[PHASE_W-1:0];
                REG_SAMPLE_COUNT:   sample_count_reg   <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: two-stage pipe, each stage moves when the one after is free.
    // Stage 1 can take a beat while a finished result waits at the output.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s2_free;
    logic s1_free;
    logic s1_load;
    logic s2_load;

    assign s2_free  = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign s1_load  = in_valid && s1_free;
    assign s2_load  = s1_valid_reg && s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Sound state, advanced once per accepted beat
    // ------------------------------------------------------------------
    logic [POSITION_WIDTH-1:0] position_reg;
    logic [POSITION_WIDTH-1:0] position_next;
    logic                      polarity_reg;
    logic                      polarity_next;
    logic [PHASE_W-1:0]        phase_reg;
    logic [PHASE_W-1:0]        phase_next;
    logic [COUNT_W-1:0]        sample_index_reg;
    logic [COUNT_W-1:0]        sample_index_next;

    // state as seen by this tick (start_req clears it first)
    logic [POSITION_WIDTH-1:0] pos_cur;
    logic                      pol_cur;
    logic [PHASE_W-1:0]        phase_cur;
    logic [COUNT_W-1:0]        index_cur;
    logic                      is_last;
    logic [SEG_W-1:0]          seg_eff;
    logic [POSITION_WIDTH-1:0] pos_inc;
    logic                      pos_wrap;
    logic [SINE_ADDR_W-1:0]    sine_addr;

    always_comb
    begin
        pos_cur   = start_req ? '0 : position_reg;
        phase_cur = start_req ? '0 : phase_reg;
        index_cur = start_req ? '0 : sample_index_reg;
        // polarity flips on the first sample of every segment
        pol_cur   = (start_req ? 1'b0 : polarity_reg) ^ (pos_cur == '0);

        is_last   = (index_cur == sample_count_reg - COUNT_W'(1));
        // zero segment length behaves as one
        seg_eff   = (segment_length_reg == '0) ? SEG_W'(1) : segment_length_reg;
        pos_inc   = pos_cur + POSITION_WIDTH'(1);
        pos_wrap  = (32'(pos_inc) >= 32'(seg_eff)) || (pos_inc == '0);

        // table index = (phase * depth) >> 32, i.e. the top phase bits
        sine_addr = phase_cur[PHASE_W-1 -: SINE_ADDR_W];

        if (is_last)
        begin
            // end of sound: everything returns to zero
            position_next     = '0;
            polarity_next     = 1'b0;
            phase_next        = '0;
            sample_index_next = '0;
        end
        else
        begin
            position_next     = pos_wrap ? '0 : pos_inc;
            polarity_next     = pol_cur;
            phase_next        = phase_cur + phase_step_reg;
            sample_index_next = index_cur + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            polarity_reg     <= 1'b0;
            phase_reg        <= '0;
            sample_index_reg <= '0;
        end
        else if (s1_load)
        begin
            position_reg     <= position_next;
            polarity_reg     <= polarity_next;
            phase_reg        <= phase_next;
            sample_index_reg <= sample_index_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 payload: registered sine ROM read and ramp product
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] s1_sine_reg;
    logic [PROD_W-1:0]          s1_prod_reg;
    logic                       s1_pol_reg;
    logic                       s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_sine_reg <= SINE_LUT[sine_addr];
            s1_prod_reg <= PROD_W'(pos_cur) * PROD_W'(slope_reg);
            s1_pol_reg  <= pol_cur;
            s1_last_reg <= is_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: waveform value. Every branch already lands in +/-32767.
    // ------------------------------------------------------------------
    logic                       sine_neg;
    logic [SAMPLE_W-1:0]        sine_abs;
    logic [2*AMP_W-1:0]         sine_prod;
    logic [AMP_W-1:0]           sine_mag;
    logic signed [SAMPLE_W-1:0] sine_val;

    logic [PROD_W-1:0]          ramp_base;
    logic                       ramp_neg;
    logic [PROD_W-1:0]          ramp_diff;
    logic [PROD_W-17:0]         ramp_shift;
    logic [AMP_W-1:0]           ramp_mag;
    logic signed [SAMPLE_W-1:0] ramp_val;

    logic signed [SAMPLE_W-1:0] amp_pos;
    logic signed [SAMPLE_W-1:0] sample_next;

    always_comb
    begin
        // sine: sign(T) * ((amplitude * |T|) >> 15)
        sine_neg  = s1_sine_reg[SAMPLE_W-1];
        sine_abs  = sine_neg ? -s1_sine_reg : s1_sine_reg;
        sine_prod = amplitude_reg * sine_abs[AMP_W-1:0];
        sine_mag  = sine_prod[2*AMP_W-1:AMP_W];
        sine_val  = sine_neg ? -{1'b0, sine_mag} : {1'b0, sine_mag};

        // ramp: (position*slope - amplitude*2^16) / 2^16, toward zero
        ramp_base  = PROD_W'({amplitude_reg, 16'h0000});
        ramp_neg   = s1_prod_reg < ramp_base;
        ramp_diff  = ramp_neg ? (ramp_base - s1_prod_reg) : (s1_prod_reg - ramp_base);
        ramp_shift = ramp_diff[PROD_W-1:16];
        ramp_mag   = (|ramp_shift[PROD_W-17:AMP_W]) ? {AMP_W{1'b1}} : ramp_shift[AMP_W-1:0];
        ramp_val   = ramp_neg ? -{1'b0, ramp_mag} : {1'b0, ramp_mag};

        amp_pos    = {1'b0, amplitude_reg};

        case (waveform_reg)
            WAVE_SINE:     sample_next = sine_val;
            WAVE_SQUARE:   sample_next = s1_pol_reg ? -amp_pos : amp_pos;
            WAVE_TRIANGLE: sample_next = s1_pol_reg ? ramp_val : -ramp_val;
            WAVE_SAWTOOTH: sample_next = ramp_val;
            default:       sample_next = ramp_val;
        endcase
    end

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            sample_reg <= sample_next;
            last_reg   <= s1_last_reg;
        end
    end

    assign sample = sample_reg;
    assign last   = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_no_overrun, s1_load && s1_valid_reg, s2_free,
        "input beat taken while stage 1 is blocked")
    `ASSERT_NEXT(a_s1_moves, s1_valid_reg && s2_free, out_valid_reg,
        "stage 1 beat lost on its way to the output")
    `ASSERT_NEXT(a_last_clears, s1_load && is_last,
        position_reg == '0 && phase_reg == '0 && sample_index_reg == '0 && !polarity_reg,
        "sound state not cleared after the last sample")
    `ASSERT_IMPL(a_no_min_sample, out_valid_reg, sample_reg != 16'sh8000,
        "sample outside +/-32767")

endmodule

>>> tb/sv/tb_multi_waveform_tone_generator.sv
// Self-checking testbench for multi_waveform_tone_generator: tick beats in, samples out.
// Predicts every sample in SystemVerilog and checks it against the result channel.
// Depends on mwtg_pkg and the RTL of the tone generator.
`timescale 1ns / 1ps

module tb_multi_waveform_tone_generator;
    import mwtg_pkg::*;

    // 1.0 and pi/2 in Q30, used to build our own copy of the sine table
    localparam logic [63:0] ONE_Q30          = 64'd1 << 30;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int          SAMPLE_MAX       = 32767;

    // indexes outside the register map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // receiver backpressure styles, picked at random by the monitor
    typedef enum logic [1:0] {
        RX_FREE,
        RX_EVERY_THIRD,
        RX_COIN,
        RX_HOLD
    } rx_mode_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } tone_beat_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       start_req = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    multi_waveform_tone_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the registers and of the sound state.
    // ------------------------------------------------------------------
    wave_t               wave_sel  = WAVE_SINE;
    logic [AMP_W-1:0]    amp_reg   = '0;
    logic [SEG_W-1:0]    seg_reg   = 24'd1;
    logic [SLOPE_W-1:0]  slope_reg = '0;
    logic [PHASE_W-1:0]  step_reg  = '0;
    logic [COUNT_W-1:0]  count_reg = 32'd1;

    logic [POSITION_WIDTH-1:0] seg_pos    = '0;
    logic                      rising     = 1'b0;   // 1: square low, triangle rising
    logic [PHASE_W-1:0]        phase_acc  = '0;
    logic [COUNT_W-1:0]        sample_idx = '0;

    logic signed [SAMPLE_W-1:0] sine_q15 [SINE_TABLE_DEPTH];

    bit         pending_ticks  [$];   // start_req of beats not yet offered
    tone_beat_t expected_tones [$];   // samples owed by the block, oldest first

    int errors     = 0;
    int ticks_sent = 0;

    // Q1.15 sine at k/DEPTH of a turn: fold into a quarter, Horner series to x^11
    function automatic logic signed [SAMPLE_W-1:0] quarter_wave_sine(input int k);
        logic [63:0] turn;
        logic [63:0] quadrant;
        logic [63:0] offs;
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] acc;
        logic [63:0] mag;
        turn     = 64'(k) * 64'd4;
        quadrant = (turn / SINE_TABLE_DEPTH) & 64'd3;
        offs     = turn % SINE_TABLE_DEPTH;
        if (quadrant[0])
        begin
            offs = 64'(SINE_TABLE_DEPTH) - offs;
        end
        ang  = (QUARTER_TURN_Q30 * offs) / SINE_TABLE_DEPTH;
        ang2 = (ang * ang) >> 30;
        acc  = ONE_Q30 - ang2 / 64'd110;
        acc  = ONE_Q30 - ((ang2 * acc) >> 30) / 64'd72;
        acc  = ONE_Q30 - ((ang2 * acc) >> 30) / 64'd42;
        acc  = ONE_Q30 - ((ang2 * acc) >> 30) / 64'd20;
        acc  = ONE_Q30 - ((ang2 * acc) >> 30) / 64'd6;
        acc  = (ang * acc) >> 30;
        if (acc > ONE_Q30)
        begin
            acc = ONE_Q30;
        end
        mag = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        return quadrant[1] ? -16'(mag) : 16'(mag);
    endfunction

    function automatic void clear_sound();
        seg_pos    = '0;
        rising     = 1'b0;
        phase_acc  = '0;
        sample_idx = '0;
    endfunction

    // (position * slope - amplitude * 2^16) / 2^16, truncated toward zero and clipped
    function automatic logic signed [31:0] ramp_level();
        logic [63:0] prod;
        logic [63:0] base;
        logic [63:0] diff;
        prod = 64'(seg_pos) * 64'(slope_reg);
        base = 64'(amp_reg) << 16;
        if (prod >= base)
        begin
            diff = (prod - base) >> 16;
            return (diff > SAMPLE_MAX) ? SAMPLE_MAX : 32'(diff);
        end
        diff = (base - prod) >> 16;
        return (diff > SAMPLE_MAX) ? -SAMPLE_MAX : -$signed(32'(diff));
    endfunction

    // One tick of the generator: returns the sample it owes and advances the state.
    function automatic tone_beat_t next_tone(input logic restart);
        tone_beat_t                beat;
        logic signed [31:0]        level;
        logic signed [SAMPLE_W-1:0] entry;
        logic [SAMPLE_W-1:0]       entry_mag;
        logic [31:0]               scaled;
        logic [SEG_W-1:0]          seg_eff;
        logic [POSITION_WIDTH:0]   pos_inc;
        if (restart)
        begin
            clear_sound();
        end
        seg_eff = (seg_reg == '0) ? 24'd1 : seg_reg;
        // a new segment begins at position zero and flips the polarity
        if (seg_pos == '0)
        begin
            rising = ~rising;
        end
        case (wave_sel)
            WAVE_SINE:
            begin
                entry     = sine_q15[phase_acc[PHASE_W-1 -: SINE_ADDR_W]];
                entry_mag = entry[SAMPLE_W-1] ? 16'(-entry) : 16'(entry);
                scaled    = (32'(amp_reg) * 32'(entry_mag)) >> 15;
                level     = entry[SAMPLE_W-1] ? -$signed(scaled) : $signed(scaled);
            end
            WAVE_SQUARE:
            begin
                level = rising ? -$signed(32'(amp_reg)) : $signed(32'(amp_reg));
            end
            WAVE_TRIANGLE:
            begin
                level = ramp_level();
                if (!rising)
                begin
                    level = -level;
                end
            end
            default:
            begin
                level = ramp_level();
            end
        endcase
        if (level > SAMPLE_MAX)
        begin
            level = SAMPLE_MAX;
        end
        if (level < -SAMPLE_MAX)
        begin
            level = -SAMPLE_MAX;
        end
        beat.sample = level[SAMPLE_W-1:0];
        // a count of zero wraps to 2^32 samples
        beat.last   = (sample_idx == count_reg - 32'd1);
        if (beat.last)
        begin
            clear_sound();
        end
        else
        begin
            phase_acc  = phase_acc + step_reg;
            pos_inc    = {1'b0, seg_pos} + 1'b1;
            // a position left above a shortened segment is used once, then wraps
            seg_pos    = (pos_inc[POSITION_WIDTH-1:0] >= seg_eff) ? '0
                                                              : pos_inc[POSITION_WIDTH-1:0];
            sample_idx = sample_idx + 32'd1;
        end
        return beat;
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 10)
        begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps. Every accepted
    // beat is run through the predictor right at the accepting edge.
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            start_req  <= 1'b0;
            gap_left   <= 0;
            burst_left <= 1;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_tones.push_back(next_tone(start_req));
            end
            // payload may only move once the current beat is gone
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_ticks.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    start_req <= pending_ticks.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        // a quarter of the bursts run straight into the next one
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stalls the result channel and checks every accepted beat.
    // ------------------------------------------------------------------
    rx_mode_t    rx_mode    = RX_FREE;
    int unsigned stall_tick = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            rx_mode    <= RX_FREE;
            stall_tick <= 0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (stall_tick % 32 == 31)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_FREE:        out_stall <= 1'b0;
                RX_EVERY_THIRD: out_stall <= (stall_tick % 3 == 0);
                RX_COIN:        out_stall <= 1'($urandom_range(0, 1));
                default:        out_stall <= (stall_tick % 32 >= 18) && (stall_tick % 32 < 30);
            endcase

            if (out_valid && !out_stall)
            begin
                if (expected_tones.size() == 0)
                begin
                    flag_error($sformatf("sample %0d last %0b with no beat owed",
                                         sample, last));
                end
                else
                begin
                    tone_beat_t want;
                    want = expected_tones.pop_front();
                    if (sample !== want.sample)
                    begin
                        flag_error($sformatf("sample: expected %0d, got %0d",
                                             $signed(want.sample), sample));
                    end
                    if (last !== want.last)
                    begin
                        flag_error($sformatf("last: expected %0b, got %0b", want.last, last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // random bits above a register's width; the block must mask them off
    function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] value,
                                                  input int width);
        logic [CFG_W-1:0] noise;
        noise = $urandom;
        noise = (width >= CFG_W) ? '0 : (noise << width);
        return noise | value;
    endfunction

    // registers change only while the block is idle, so the shadow copy follows at once
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_WAVEFORM:       wave_sel  = wave_t'(data[1:0]);
            REG_AMPLITUDE:      amp_reg   = data[AMP_W-1:0];
            REG_SEGMENT_LENGTH: seg_reg   = data[SEG_W-1:0];
            REG_SLOPE:          slope_reg = data[SLOPE_W-1:0];
            REG_PHASE_STEP:     step_reg  = data[PHASE_W-1:0];
            REG_SAMPLE_COUNT:   count_reg = data[COUNT_W-1:0];
            default:            ;
        endcase
    endtask

    // waits until nothing is left to offer and nothing is in flight, plus a margin
    task automatic settle();
        while (pending_ticks.size() != 0 || in_valid || expected_tones.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Ends any register writes, offers n ticks and waits for all their samples.
    // The wait at the end is also the sender's full pause until nothing is owed.
    task automatic play(input int n, input int restart_pct, input bit lead_restart);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            pending_ticks.push_back((i == 0 && lead_restart) ? 1'b1
                                    : ($urandom_range(0, 99) < restart_pct));
        end
        ticks_sent += n;
        settle();
    endtask

    initial
    begin
        int          n_items;
        int          pct;
        int          pick;
        logic [63:0] slope_calc;
        logic [SEG_W-1:0] seg_eff;

        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            sine_q15[k] = quarter_wave_sine(k);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // --- directed part ---
        // reset defaults: sine at zero amplitude, one-sample sounds
        play(2, 0, 0);

        // square at full amplitude; zero segment length behaves as one, so it
        // toggles every sample, starting low
        write_reg(REG_WAVEFORM, with_junk(WAVE_SQUARE, 2));
        write_reg(REG_AMPLITUDE, with_junk(15'h7FFF, AMP_W));
        write_reg(REG_SEGMENT_LENGTH, with_junk(24'd0, SEG_W));
        write_reg(REG_SAMPLE_COUNT, 32'd4);
        play(4, 0, 1);

        // triangle with the steepest slope saturates; a zero count wraps to 2^32 samples
        write_reg(REG_WAVEFORM, with_junk(WAVE_TRIANGLE, 2));
        write_reg(REG_SEGMENT_LENGTH, with_junk(24'd3, SEG_W));
        write_reg(REG_SLOPE, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLE_COUNT, 32'd0);
        play(4, 0, 1);

        // sawtooth that reads back the position, then the segment is cut below it
        write_reg(REG_WAVEFORM, with_junk(WAVE_SAWTOOTH, 2));
        write_reg(REG_AMPLITUDE, with_junk(15'd0, AMP_W));
        write_reg(REG_SLOPE, 32'h0001_0000);
        write_reg(REG_SEGMENT_LENGTH, with_junk(24'd16, SEG_W));
        play(10, 0, 1);
        write_reg(REG_SEGMENT_LENGTH, with_junk(24'd4, SEG_W));
        play(3, 0, 0);

        // sine in quarter turns at full amplitude; writes off the map change nothing
        write_reg(REG_WAVEFORM, with_junk(WAVE_SINE, 2));
        write_reg(REG_AMPLITUDE, with_junk(15'h7FFF, AMP_W));
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_SAMPLE_COUNT, 32'd3);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        play(3, 0, 1);

        // --- random part: one register setting per phase, state carried across ---
        while (ticks_sent < 1810)
        begin
            write_reg(REG_WAVEFORM, with_junk(CFG_W'($urandom_range(0, 3)), 2));

            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                write_reg(REG_AMPLITUDE, with_junk((pick == 0) ? 15'd0 :
                                                   (pick == 1) ? 15'h7FFF :
                                                   15'($urandom), AMP_W));
            end

            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                write_reg(REG_SEGMENT_LENGTH, with_junk((pick < 7) ? 24'($urandom_range(1, 40)) :
                                                        (pick == 7) ? 24'($urandom_range(0, 1)) :
                                                        (pick == 8) ? 24'hFF_FFFF :
                                                        24'($urandom), SEG_W));
            end

            if ($urandom_range(0, 3) != 0)
            begin
                // half the time a slope that sweeps about twice the amplitude per segment
                seg_eff    = (seg_reg == '0) ? 24'd1 : seg_reg;
                slope_calc = ((64'(amp_reg) << 17) / seg_eff) + 64'($urandom_range(0, 255));
                pick       = $urandom_range(0, 3);
                write_reg(REG_SLOPE, (pick < 2) ? slope_calc[31:0] :
                                     (pick == 2) ? 32'($urandom_range(0, 32'h3FFFF)) :
                                     32'($urandom));
            end

            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                write_reg(REG_PHASE_STEP, (pick < 4) ? 32'($urandom) :
                                          (pick < 8) ? 32'($urandom_range(0, 32'h0400_0000)) :
                                          (pick == 8) ? 32'd0 : 32'h8000_0000);
            end

            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 19);
                write_reg(REG_SAMPLE_COUNT, (pick < 12) ? 32'($urandom_range(1, 64)) :
                                            (pick < 15) ? 32'($urandom_range(65, 4000)) :
                                            (pick < 17) ? 32'd0 :
                                            (pick < 19) ? 32'hFFFF_FFFF : 32'($urandom));
            end

            if ($urandom_range(0, 9) == 0)
            begin
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
            end

            n_items = $urandom_range(8, 120);
            pick    = $urandom_range(0, 2);
            pct     = (pick == 0) ? 0 : (pick == 1) ? 2 : 10;
            play(n_items, pct, $urandom_range(0, 1));
        end

        // drained already; give the pipeline time to show any stray beat
        repeat (8) @(posedge clk);
        if (expected_tones.size() != 0)
        begin
            flag_error($sformatf("%0d samples never came out", expected_tones.size()));
        end
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
